FILE: rtl/core/rvalu_pkg.sv
// ----------------------------------------------------------------------------
// rvalu_pkg: shared types and constants for the rv64i integer execute unit
// operation codes, decoded control and queue entry layout
// ----------------------------------------------------------------------------
package rvalu_pkg;

    // field widths
    localparam int OP_W    = 5;
    localparam int IDX_W   = 5;
    localparam int IMM_W   = 12;
    localparam int XLEN    = 64;
    localparam int RF_DEPTH = 31;

    // operation codes as they arrive on the request channel
    localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 5'd1;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd2;
    localparam logic [OP_W-1:0] OP_OR    = 5'd3;
    localparam logic [OP_W-1:0] OP_AND   = 5'd4;
    localparam logic [OP_W-1:0] OP_SLL   = 5'd5;
    localparam logic [OP_W-1:0] OP_SRL   = 5'd6;
    localparam logic [OP_W-1:0] OP_SRA   = 5'd7;
    localparam logic [OP_W-1:0] OP_SLT   = 5'd8;
    localparam logic [OP_W-1:0] OP_SLTU  = 5'd9;
    localparam logic [OP_W-1:0] OP_ADDI  = 5'd10;
    localparam logic [OP_W-1:0] OP_XORI  = 5'd11;
    localparam logic [OP_W-1:0] OP_ORI   = 5'd12;
    localparam logic [OP_W-1:0] OP_ANDI  = 5'd13;
    localparam logic [OP_W-1:0] OP_SLLI  = 5'd14;
    localparam logic [OP_W-1:0] OP_SRLI  = 5'd15;
    localparam logic [OP_W-1:0] OP_SRAI  = 5'd16;
    localparam logic [OP_W-1:0] OP_SLTI  = 5'd17;
    localparam logic [OP_W-1:0] OP_SLTIU = 5'd18;
    localparam logic [OP_W-1:0] OP_ADDW  = 5'd19;
    localparam logic [OP_W-1:0] OP_SUBW  = 5'd20;
    localparam logic [OP_W-1:0] OP_SLLW  = 5'd21;
    localparam logic [OP_W-1:0] OP_SRLW  = 5'd22;
    localparam logic [OP_W-1:0] OP_SRAW  = 5'd23;
    localparam logic [OP_W-1:0] OP_ADDIW = 5'd24;
    localparam logic [OP_W-1:0] OP_SLLIW = 5'd25;
    localparam logic [OP_W-1:0] OP_SRLIW = 5'd26;
    localparam logic [OP_W-1:0] OP_SRAIW = 5'd27;

    // execution class after decode
    typedef enum logic [3:0] {
        KIND_ADD,
        KIND_SUB,
        KIND_XOR,
        KIND_OR,
        KIND_AND,
        KIND_SLL,
        KIND_SRL,
        KIND_SRA,
        KIND_SLT,
        KIND_SLTU,
        KIND_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        logic     use_imm;
        logic     word;
    } ctrl_t;

    typedef struct packed {
        ctrl_t            ctrl;
        logic [IDX_W-1:0] src1;
        logic [IDX_W-1:0] src2;
        logic [IDX_W-1:0] dest;
        logic [IMM_W-1:0] imm;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // sign-extend the low word to 64 bits
    function automatic logic [XLEN-1:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

FILE: rtl/core/rv64i_integer_alu_execute_unit.sv
// ----------------------------------------------------------------------------
// rv64i_integer_alu_execute_unit: rv64i integer alu execute stage
// executes decoded register and immediate alu instructions on x0..x31
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one decoded instruction request per accepted cycle;
//   m_* channel returns one result per request, in request order.
//   requests are decoded into a two-entry queue; the back end reads the
//   register file, executes and writes back, then parks the result in an
//   output register.
//   path: the queue is written at acceptance, the register read fills the
//   execute stage registers, and execute writes the output register that
//   drives m_tvalid.
//   throughput: one request per cycle while m_tready holds, set by the
//   single execute stage; back-to-back dependent instructions see the
//   previous result through a bypass from the output register.
//   reset: queue and pipeline empty, x1..x31 read as zero (per-entry valid
//   bits cleared at once, no clearing pass).
//   receiver stall: the output register holds its result, the execute stage
//   holds, and the queue keeps accepting until both entries are full; then
//   s_tready drops.
// ----------------------------------------------------------------------------
module rv64i_integer_alu_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[4:0], src1_index[9:5], src2_index[14:10], dest_index[19:15],
    // immediate[31:20]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_index[4:0], result_value[68:5], result_written[69], zero[71:70]
    output logic [71:0] m_tdata
);
    import rvalu_pkg::*;

    entry_t    dec_entry;
    entry_t    q_head;
    q_status_t q_status;
    logic      push;
    logic      pop;

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    // front: decode
    rvalu_front u_front (
        .s_tdata (s_tdata),
        .entry   (dec_entry)
    );

    // queue between decode and execute
    rvalu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (dec_entry),
        .pop        (pop),
        .head       (q_head),
        .status     (q_status)
    );

    // back: read, execute, writeback
    rvalu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_status.empty),
        .head       (q_head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // x0 is never reported as written
    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[69] && (m_tdata[4:0] == 5'd0)))
        else $error("result reports a write to x0");

    // an unwritten result with a real destination comes from an unused code
    a_nop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[69] && (m_tdata[4:0] != 5'd0))
            |-> (m_tdata[68:5] == 64'd0))
        else $error("discarded result carries a nonzero value");

    // an accepted request is held in the queue on the next cycle
    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_status.empty)
        else $error("accepted request lost from queue");

    // the back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

FILE: rtl/core/rvalu_front.sv
// ----------------------------------------------------------------------------
// rvalu_front: request decode
// unpacks the request word and classifies the operation code
// ----------------------------------------------------------------------------
module rvalu_front (
    input  logic [31:0]     s_tdata,
    output rvalu_pkg::entry_t entry
);
    import rvalu_pkg::*;

    logic [OP_W-1:0] op;
    ctrl_t           ctrl;

    assign op = s_tdata[4:0];

    // operation code to execution class
    always_comb
    begin
        ctrl.kind    = KIND_NOP;
        ctrl.use_imm = 1'b0;
        ctrl.word    = 1'b0;
        case (op)
            OP_ADD:   ctrl.kind = KIND_ADD;
            OP_SUB:   ctrl.kind = KIND_SUB;
            OP_XOR:   ctrl.kind = KIND_XOR;
            OP_OR:    ctrl.kind = KIND_OR;
            OP_AND:   ctrl.kind = KIND_AND;
            OP_SLL:   ctrl.kind = KIND_SLL;
            OP_SRL:   ctrl.kind = KIND_SRL;
            OP_SRA:   ctrl.kind = KIND_SRA;
            OP_SLT:   ctrl.kind = KIND_SLT;
            OP_SLTU:  ctrl.kind = KIND_SLTU;
            OP_ADDI:  begin ctrl.kind = KIND_ADD;  ctrl.use_imm = 1'b1; end
            OP_XORI:  begin ctrl.kind = KIND_XOR;  ctrl.use_imm = 1'b1; end
            OP_ORI:   begin ctrl.kind = KIND_OR;   ctrl.use_imm = 1'b1; end
            OP_ANDI:  begin ctrl.kind = KIND_AND;  ctrl.use_imm = 1'b1; end
            OP_SLLI:  begin ctrl.kind = KIND_SLL;  ctrl.use_imm = 1'b1; end
            OP_SRLI:  begin ctrl.kind = KIND_SRL;  ctrl.use_imm = 1'b1; end
            OP_SRAI:  begin ctrl.kind = KIND_SRA;  ctrl.use_imm = 1'b1; end
            OP_SLTI:  begin ctrl.kind = KIND_SLT;  ctrl.use_imm = 1'b1; end
            OP_SLTIU: begin ctrl.kind = KIND_SLTU; ctrl.use_imm = 1'b1; end
            OP_ADDW:  begin ctrl.kind = KIND_ADD;  ctrl.word = 1'b1; end
            OP_SUBW:  begin ctrl.kind = KIND_SUB;  ctrl.word = 1'b1; end
            OP_SLLW:  begin ctrl.kind = KIND_SLL;  ctrl.word = 1'b1; end
            OP_SRLW:  begin ctrl.kind = KIND_SRL;  ctrl.word = 1'b1; end
            OP_SRAW:  begin ctrl.kind = KIND_SRA;  ctrl.word = 1'b1; end
            OP_ADDIW:
            begin
                ctrl.kind = KIND_ADD; ctrl.use_imm = 1'b1; ctrl.word = 1'b1;
            end
            OP_SLLIW:
            begin
                ctrl.kind = KIND_SLL; ctrl.use_imm = 1'b1; ctrl.word = 1'b1;
            end
            OP_SRLIW:
            begin
                ctrl.kind = KIND_SRL; ctrl.use_imm = 1'b1; ctrl.word = 1'b1;
            end
            OP_SRAIW:
            begin
                ctrl.kind = KIND_SRA; ctrl.use_imm = 1'b1; ctrl.word = 1'b1;
            end
            default:  ctrl.kind = KIND_NOP;
        endcase
    end

    // pack the queue entry
    assign entry.ctrl = ctrl;
    assign entry.src1 = s_tdata[9:5];
    assign entry.src2 = s_tdata[14:10];
    assign entry.dest = s_tdata[19:15];
    assign entry.imm  = s_tdata[31:20];

endmodule

FILE: rtl/core/rvalu_queue.sv
// ----------------------------------------------------------------------------
// rvalu_queue: two-entry request queue
// decouples request decode from register read and execute
// ----------------------------------------------------------------------------
module rvalu_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rvalu_pkg::entry_t    push_entry,
    input  logic                 pop,
    output rvalu_pkg::entry_t    head,
    output rvalu_pkg::q_status_t status
);
    import rvalu_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

endmodule

FILE: rtl/core/rvalu_back.sv
// ----------------------------------------------------------------------------
// rvalu_back: register read, execute and writeback
// reads x1..x31, computes the alu result, updates the register file and
// holds the result in the output register
// ----------------------------------------------------------------------------
module rvalu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  rvalu_pkg::entry_t    head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata
);
    import rvalu_pkg::*;

    // register file: data array plus per-entry valid for reset-to-zero
    logic [XLEN-1:0]     rf_mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] rf_valid_reg;

    // execute stage
    logic             e_valid_reg;
    ctrl_t            e_ctrl_reg;
    logic [IDX_W-1:0] e_dest_reg;
    logic [IMM_W-1:0] e_imm_reg;
    logic [XLEN-1:0]  rdata1_reg, rdata2_reg;
    logic             src1_ok_reg, src2_ok_reg;
    logic             byp1_reg, byp2_reg;

    // output register
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [XLEN-1:0]  out_value_reg;
    logic             out_written_reg;

    logic             e_adv;
    logic             e_write;
    logic [IDX_W-1:0] rd1_idx, rd2_idx, wr_idx;
    logic             src1_ok_next, src2_ok_next;
    logic [XLEN-1:0]  op_a, op_b, r2, imm_ext;
    logic [5:0]       amt;
    logic [XLEN-1:0]  sum, diff, shl, shr, sra;
    logic [31:0]      shl_w, shr_w, sra_w;
    logic [XLEN-1:0]  e_result;

    // stage handshakes
    assign e_adv   = e_valid_reg && (!out_valid_reg || m_tready);
    assign pop     = head_valid && (!e_valid_reg || e_adv);
    assign e_write = (e_ctrl_reg.kind != KIND_NOP) && (e_dest_reg != '0);

    // register file addressing (x0 is not stored)
    assign rd1_idx = head.src1 - 5'd1;
    assign rd2_idx = head.src2 - 5'd1;
    assign wr_idx  = e_dest_reg - 5'd1;
    assign src1_ok_next = (head.src1 != '0) ? rf_valid_reg[rd1_idx] : 1'b0;
    assign src2_ok_next = (head.src2 != '0) ? rf_valid_reg[rd2_idx] : 1'b0;

    // register file read and write
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rdata1_reg <= rf_mem[rd1_idx];
            rdata2_reg <= rf_mem[rd2_idx];
        end
        if (e_adv && e_write)
        begin
            rf_mem[wr_idx] <= e_result;
        end
    end

    // entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
        end
        else if (e_adv && e_write)
        begin
            rf_valid_reg[wr_idx] <= 1'b1;
        end
    end

    // execute stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            e_valid_reg <= 1'b1;
        end
        else if (e_adv)
        begin
            e_valid_reg <= 1'b0;
        end
    end

    // execute stage payload, bypass from the result being written this cycle
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_ctrl_reg  <= head.ctrl;
            e_dest_reg  <= head.dest;
            e_imm_reg   <= head.imm;
            src1_ok_reg <= src1_ok_next;
            src2_ok_reg <= src2_ok_next;
            byp1_reg    <= e_adv && e_write && (e_dest_reg == head.src1);
            byp2_reg    <= e_adv && e_write && (e_dest_reg == head.src2);
        end
    end

    // operand select; out_value_reg holds the last executed result
    assign op_a = byp1_reg ? out_value_reg : (src1_ok_reg ? rdata1_reg : '0);
    assign r2   = byp2_reg ? out_value_reg : (src2_ok_reg ? rdata2_reg : '0);
    assign imm_ext = {{(XLEN-IMM_W){e_imm_reg[IMM_W-1]}}, e_imm_reg};
    assign op_b = e_ctrl_reg.use_imm ? imm_ext : r2;
    assign amt  = e_ctrl_reg.word ? {1'b0, op_b[4:0]} : op_b[5:0];

    // datapath
    assign sum   = op_a + op_b;
    assign diff  = op_a - op_b;
    assign shl   = op_a << amt;
    assign shr   = op_a >> amt;
    assign sra   = $signed(op_a) >>> amt;
    assign shl_w = op_a[31:0] << amt[4:0];
    assign shr_w = op_a[31:0] >> amt[4:0];
    assign sra_w = $signed(op_a[31:0]) >>> amt[4:0];

    // result select
    always_comb
    begin
        case (e_ctrl_reg.kind)
            KIND_ADD:  e_result = e_ctrl_reg.word ? sext32(sum[31:0]) : sum;
            KIND_SUB:  e_result = e_ctrl_reg.word ? sext32(diff[31:0]) : diff;
            KIND_XOR:  e_result = op_a ^ op_b;
            KIND_OR:   e_result = op_a | op_b;
            KIND_AND:  e_result = op_a & op_b;
            KIND_SLL:  e_result = e_ctrl_reg.word ? sext32(shl_w) : shl;
            KIND_SRL:  e_result = e_ctrl_reg.word ? sext32(shr_w) : shr;
            KIND_SRA:  e_result = e_ctrl_reg.word ? sext32(sra_w) : sra;
            KIND_SLT:
                e_result = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
            KIND_SLTU: e_result = {{(XLEN-1){1'b0}}, (op_a < op_b)};
            default:   e_result = '0;
        endcase
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (e_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (e_adv)
        begin
            out_index_reg   <= e_dest_reg;
            out_value_reg   <= e_result;
            out_written_reg <= e_write;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_written_reg, out_value_reg, out_index_reg};

endmodule

FILE: tb/rv64i_alu_result_checker.sv
// ----------------------------------------------------------------------------
// rv64i_alu_result_checker: scoreboard for the rv64i integer execute unit
// keeps its own copy of x1..x31, works out each writeback at request time and
// compares it with the results that leave the unit, oldest first
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rv64i_alu_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // operation, src1_index, src2_index, dest_index, immediate
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // result_index, result_value, result_written, zero
    input  logic [71:0] m_tdata,
    output int          error_count,
    output int          pending_results
);
    import rvalu_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic [XLEN-1:0]  value;
        logic             written;
    } writeback_t;

    logic [XLEN-1:0] arch_regs [1:RF_DEPTH];
    writeback_t      expected_writebacks [$];

    // register read with x0 hardwired to zero
    function automatic logic [XLEN-1:0] read_arch_reg(input logic [IDX_W-1:0] idx);
        if (idx == '0)
            return '0;
        return arch_regs[idx];
    endfunction

    function automatic logic uses_immediate(input logic [OP_W-1:0] op);
        return (op >= OP_ADDI && op <= OP_SLTIU) || (op >= OP_ADDIW && op <= OP_SRAIW);
    endfunction

    // value for the destination; second operand is already register or immediate
    function automatic logic [XLEN-1:0] alu_result_value(input logic [OP_W-1:0] op,
                                                         input logic [XLEN-1:0] a,
                                                         input logic [XLEN-1:0] b);
        logic [31:0]     w;
        logic [XLEN-1:0] v;
        v = '0;
        w = '0;
        case (op)
            OP_ADD, OP_ADDI:   v = a + b;
            OP_SUB:            v = a - b;
            OP_XOR, OP_XORI:   v = a ^ b;
            OP_OR, OP_ORI:     v = a | b;
            OP_AND, OP_ANDI:   v = a & b;
            OP_SLL, OP_SLLI:   v = a << b[5:0];
            OP_SRL, OP_SRLI:   v = a >> b[5:0];
            OP_SRA, OP_SRAI:   v = $signed(a) >>> b[5:0];
            OP_SLT, OP_SLTI:   v = {63'd0, $signed(a) < $signed(b)};
            OP_SLTU, OP_SLTIU: v = {63'd0, a < b};
            OP_ADDW, OP_ADDIW: w = a[31:0] + b[31:0];
            OP_SUBW:           w = a[31:0] - b[31:0];
            OP_SLLW, OP_SLLIW: w = a[31:0] << b[4:0];
            OP_SRLW, OP_SRLIW: w = a[31:0] >> b[4:0];
            OP_SRAW, OP_SRAIW: w = $signed(a[31:0]) >>> b[4:0];
            default:           v = '0;
        endcase
        // word forms sign-extend from bit 31
        if (op >= OP_ADDW && op <= OP_SRAIW)
            v = {{32{w[31]}}, w};
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        writeback_t       want;
        writeback_t       got;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] rs1;
        logic [IDX_W-1:0] rs2;
        logic [IDX_W-1:0] rd;
        logic [XLEN-1:0]  imm64;
        logic [XLEN-1:0]  operand_b;
        if (!rst_n)
        begin
            for (int i = 1; i <= RF_DEPTH; i++)
                arch_regs[i] = '0;
            expected_writebacks.delete();
            error_count     <= 0;
            pending_results <= 0;
        end
        else
        begin
            // results leave in request order, so compare against the oldest
            if (m_tvalid && m_tready)
            begin
                got.index   = m_tdata[4:0];
                got.value   = m_tdata[68:5];
                got.written = m_tdata[69];
                if (expected_writebacks.size() == 0)
                begin
                    $display({"%0t: unexpected result: expected none, ",
                              "actual index %0d value %h written %b"},
                             $time, got.index, got.value, got.written);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_writebacks.pop_front();
                    if (got.index !== want.index || got.value !== want.value ||
                        got.written !== want.written)
                    begin
                        $display({"%0t: result mismatch: ",
                                  "expected index %0d value %h written %b, ",
                                  "actual index %0d value %h written %b"},
                                 $time, want.index, want.value, want.written,
                                 got.index, got.value, got.written);
                        error_count <= error_count + 1;
                    end
                end
            end

            // predict the writeback of each accepted request
            if (s_tvalid && s_tready)
            begin
                op    = s_tdata[4:0];
                rs1   = s_tdata[9:5];
                rs2   = s_tdata[14:10];
                rd    = s_tdata[19:15];
                imm64 = {{52{s_tdata[31]}}, s_tdata[31:20]};
                operand_b = uses_immediate(op) ? imm64 : read_arch_reg(rs2);
                want.index   = rd;
                want.value   = alu_result_value(op, read_arch_reg(rs1), operand_b);
                want.written = (op <= OP_SRAIW) && (rd != '0);
                if (want.written)
                    arch_regs[rd] = want.value;
                expected_writebacks.push_back(want);
            end

            pending_results <= expected_writebacks.size();
        end
    end

endmodule

FILE: tb/rv64i_integer_alu_execute_unit_tb.sv
// ----------------------------------------------------------------------------
// rv64i_integer_alu_execute_unit_tb: top level bench for the integer execute unit
// drives directed and random instruction requests with random idle and stall
// patterns; the result checker predicts and compares every writeback
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rv64i_integer_alu_execute_unit_tb;
    import rvalu_pkg::*;

    // reserved operation codes above the last defined one
    localparam logic [OP_W-1:0] OP_RESERVED_LO = 5'd28;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 5'd31;
    localparam int RANDOM_PER_PHASE = 235;
    localparam int HOLD_OFF_CYCLES  = 80;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    int error_count;
    int pending_results;
    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_off_request;

    rv64i_integer_alu_execute_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rv64i_alu_result_checker result_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    // offer one request, starting and ending at a falling edge
    task automatic issue_instruction(input logic [OP_W-1:0] op,
                                     input logic [IDX_W-1:0] rs1,
                                     input logic [IDX_W-1:0] rs2,
                                     input logic [IDX_W-1:0] rd,
                                     input logic [IMM_W-1:0] imm);
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {imm, rd, rs2, rs1, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random instruction with a bias toward edge immediates
    task automatic issue_random_instruction();
        logic [OP_W-1:0]  op;
        logic [IMM_W-1:0] imm;
        if ($urandom_range(19, 0) == 0)
            op = OP_W'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO));
        else
            op = OP_W'($urandom_range(OP_SRAIW, OP_ADD));
        case ($urandom_range(9, 0))
            0:       imm = 12'h800;
            1:       imm = 12'h7ff;
            2:       imm = 12'hfff;
            3:       imm = {6'd0, 6'($urandom_range(63, 0))};
            default: imm = IMM_W'($urandom);
        endcase
        issue_instruction(op, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom), imm);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        wait (pending_results == 0);
        @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        hold_off_request = 1'b0;
        sender_idle_pct = 15;
        receiver_stall_pct = 74;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes of the immediate, masked shift amounts and every operation
        issue_instruction(OP_ADDI,  5'd0,  5'd0,  5'd1,  12'h800);
        issue_instruction(OP_ADDI,  5'd0,  5'd0,  5'd2,  12'h7ff);
        issue_instruction(OP_SLLI,  5'd2,  5'd0,  5'd3,  12'd52);
        issue_instruction(OP_SRAI,  5'd1,  5'd0,  5'd4,  12'hfff);
        issue_instruction(OP_SRLI,  5'd4,  5'd0,  5'd5,  12'hfff);
        issue_instruction(OP_ADD,   5'd3,  5'd3,  5'd6,  12'd0);
        issue_instruction(OP_SUB,   5'd0,  5'd2,  5'd7,  12'd0);
        issue_instruction(OP_XOR,   5'd4,  5'd3,  5'd8,  12'd0);
        issue_instruction(OP_OR,    5'd1,  5'd2,  5'd9,  12'd0);
        issue_instruction(OP_AND,   5'd4,  5'd3,  5'd10, 12'd0);
        issue_instruction(OP_SLL,   5'd5,  5'd2,  5'd11, 12'd0);
        issue_instruction(OP_SRL,   5'd11, 5'd2,  5'd12, 12'd0);
        issue_instruction(OP_SRA,   5'd11, 5'd7,  5'd13, 12'd0);
        issue_instruction(OP_SLT,   5'd1,  5'd2,  5'd14, 12'd0);
        issue_instruction(OP_SLTU,  5'd1,  5'd2,  5'd15, 12'd0);
        issue_instruction(OP_XORI,  5'd3,  5'd0,  5'd16, 12'hfff);
        issue_instruction(OP_ORI,   5'd0,  5'd0,  5'd17, 12'h800);
        issue_instruction(OP_ANDI,  5'd4,  5'd0,  5'd18, 12'h7ff);
        issue_instruction(OP_SLTI,  5'd11, 5'd0,  5'd19, 12'h800);
        issue_instruction(OP_SLTIU, 5'd5,  5'd0,  5'd20, 12'hfff);
        issue_instruction(OP_ADDW,  5'd4,  5'd5,  5'd21, 12'd0);
        issue_instruction(OP_SUBW,  5'd0,  5'd1,  5'd22, 12'd0);
        issue_instruction(OP_SLLW,  5'd4,  5'd2,  5'd23, 12'd0);
        issue_instruction(OP_SRLW,  5'd4,  5'd5,  5'd24, 12'd0);
        issue_instruction(OP_SRAW,  5'd23, 5'd5,  5'd25, 12'd0);
        issue_instruction(OP_ADDIW, 5'd24, 5'd0,  5'd26, 12'd1);
        issue_instruction(OP_SLLIW, 5'd5,  5'd0,  5'd27, 12'hfff);
        issue_instruction(OP_SRLIW, 5'd4,  5'd0,  5'd28, 12'hfff);
        issue_instruction(OP_SRAIW, 5'd27, 5'd0,  5'd29, 12'd31);
        // destination x0 keeps the value but does not write
        issue_instruction(OP_ADD,   5'd1,  5'd2,  5'd0,  12'd0);
        issue_instruction(OP_RESERVED_LO, 5'd1, 5'd2, 5'd30, 12'h7ff);
        issue_instruction(OP_RESERVED_HI, 5'd4, 5'd4, 5'd31, 12'h800);
        wait_for_results();

        // random phases: sender idles less, then more, then never
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct    = (phase == 0) ? 15 : (phase == 1) ? 74 : 0;
            receiver_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 15 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // long receiver hold-off while requests keep coming
                if (n == 60)
                    hold_off_request = 1'b1;
                if (n == 150)
                    wait_for_results();
                issue_random_instruction();
            end
        end
        s_tvalid <= 1'b0;

        wait (pending_results == 0);
        repeat (10) @(posedge clk);
        if (error_count == 0 && pending_results == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
